@@ rtl/core/ssfa_pkg.sv @@
package ssfa_pkg;

  localparam int MaxSlots   = 64;
  localparam int OffsetBits = 16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [OffsetBits-1:0] request_size;
    logic [OffsetBits-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [OffsetBits-1:0] slot_offset;
    logic [1:0]            status;
    logic [OffsetBits-1:0] stack_top;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AREAD,
    S_ACHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_FREAD,
    S_FCHECK,
    S_FNEIGH,
    S_FMERGE,
    S_RMV_RD,
    S_RMV_WR,
    S_TOP_RD,
    S_TOP,
    S_DONE
  } state_e;

endpackage

@@ rtl/core/stack_slot_first_fit_allocator_unit.sv @@
// Channel  | Signals                  | Handshake
// command  | start_i, req_i, busy_o   | accepted when start_i is high and busy_o is low
// result   | rsp_valid_o, rsp_o       | one cycle strobe, the receiver cannot stall
//
// A transaction scans the slots in order, shifts the table by one entry per moved
// slot when it splits or removes a slot, then fetches the stack top; a free that
// merges on both sides shifts the table twice. The slot memory has one read port
// and one write port, and is read one entry per cycle.
// Reset clears the FSM state and the slot count only; slot memory is undefined until written.
// busy_o stays high from acceptance through the result strobe cycle.
module stack_slot_first_fit_allocator_unit #(
  parameter int MAX_SLOTS = ssfa_pkg::MaxSlots
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ssfa_pkg::req_t req_i,
  output logic           busy_o,
  output logic           rsp_valid_o,
  output ssfa_pkg::rsp_t rsp_o
);

  localparam int OFFSET_BITS = ssfa_pkg::OffsetBits;
  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int EW = 2 * OFFSET_BITS + 1;
  localparam logic [OFFSET_BITS:0] OffMax = {1'b0, {OFFSET_BITS{1'b1}}};

  // Each slot entry is {start, end, used} in one memory word.
  logic [EW-1:0] mem [MAX_SLOTS];
  logic [EW-1:0] rdata_q;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  logic [OFFSET_BITS-1:0] r_start, r_end;
  logic                   r_used;
  assign r_start = rdata_q[EW-1 -: OFFSET_BITS];
  assign r_end   = rdata_q[OFFSET_BITS:1];
  assign r_used  = rdata_q[0];

  ssfa_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;          // current scan index
  logic [CW-1:0] j_q, j_d;          // shift index
  logic [CW-1:0] lim_q, lim_d;      // shift limit
  logic [OFFSET_BITS-1:0] sz_q, sz_d, addr_q, addr_d;
  logic [OFFSET_BITS-1:0] cs_q, cs_d, ce_q, ce_d;  // entry k start, end
  logic [OFFSET_BITS-1:0] off_q, off_d, top_q, top_d;
  logic [1:0]    st_q, st_d;
  logic          pfree_q, pfree_d;  // previous free, fetched during free
  logic          split_q, split_d;  // split pending after gap open
  logic          merge_p_q, merge_p_d;

  logic [OFFSET_BITS-1:0] have;
  assign have = r_end - r_start;    // shared subtract

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssfa_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; j_q <= j_d; lim_q <= lim_d;
    sz_q <= sz_d; addr_q <= addr_d; cs_q <= cs_d; ce_q <= ce_d;
    off_q <= off_d; top_q <= top_d; st_q <= st_d;
    pfree_q <= pfree_d;
    split_q <= split_d; merge_p_q <= merge_p_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; k_d = k_q; j_d = j_q; lim_d = lim_q;
    sz_d = sz_q; addr_d = addr_q; cs_d = cs_q; ce_d = ce_q;
    off_d = off_q; top_d = top_q; st_d = st_q;
    pfree_d = pfree_q; split_d = split_q;
    merge_p_d = merge_p_q;
    raddr = k_q[IW-1:0]; waddr = k_q[IW-1:0]; we = 1'b0; wdata = rdata_q;
    case (state_q)
      ssfa_pkg::S_IDLE: begin
        if (start_i) begin
          sz_d = req_i.request_size[OFFSET_BITS-1:0];
          addr_d = req_i.free_address[OFFSET_BITS-1:0];
          k_d = '0; off_d = '0; st_d = ssfa_pkg::ST_OK; pfree_d = 1'b0;
          split_d = 1'b0; merge_p_d = 1'b0;
          raddr = '0;
          case (ssfa_pkg::opcode_e'(req_i.opcode))
            ssfa_pkg::OP_ALLOC: state_d = ssfa_pkg::S_AREAD;
            ssfa_pkg::OP_FREE:  state_d = ssfa_pkg::S_FREAD;
            ssfa_pkg::OP_CLEAR: begin
              cnt_d = '0; state_d = ssfa_pkg::S_TOP_RD;
            end
            default: state_d = ssfa_pkg::S_TOP_RD;
          endcase
        end
      end
      // Allocate: memory read of entry k was issued; wait for data.
      ssfa_pkg::S_AREAD: begin
        if (k_q >= cnt_q) begin
          state_d = ssfa_pkg::S_TOP_RD; split_d = 1'b0;
          if (cnt_q >= CW'(MAX_SLOTS)) begin
            st_d = ssfa_pkg::ST_FULL;
          end else begin
            merge_p_d = 1'b1;  // marks append path
          end
        end else begin
          state_d = ssfa_pkg::S_ACHECK;
        end
      end
      ssfa_pkg::S_ACHECK: begin
        cs_d = r_start; ce_d = r_end;
        if (!r_used && have > sz_q) begin
          if (cnt_q >= CW'(MAX_SLOTS)) begin
            st_d = ssfa_pkg::ST_FULL; state_d = ssfa_pkg::S_TOP_RD;
          end else begin
            // shift entries k+1..cnt-1 up by one, from the top down
            split_d = 1'b1; j_d = cnt_q; lim_d = k_q + CW'(1);
            state_d = ssfa_pkg::S_SHIFT_RD;
          end
        end else if (!r_used && have == sz_q) begin
          we = 1'b1; wdata = {r_start, r_end, 1'b1};
          off_d = r_start; state_d = ssfa_pkg::S_TOP_RD;
        end else begin
          k_d = k_q + CW'(1); raddr = IW'(k_q + CW'(1));
          state_d = ssfa_pkg::S_AREAD;
        end
      end
      ssfa_pkg::S_SHIFT_RD: begin
        if (split_q) begin
          if (j_q > lim_q) begin
            raddr = IW'(j_q - CW'(1)); state_d = ssfa_pkg::S_SHIFT_WR;
          end else begin
            we = 1'b1; waddr = IW'(k_q);
            wdata = {cs_q, cs_q + sz_q, 1'b1};
            off_d = cs_q; state_d = ssfa_pkg::S_APPEND;
          end
        end else begin
          // removal: move j+1 down to j for j < lim-1
          if (j_q + CW'(1) < lim_q) begin
            raddr = IW'(j_q + CW'(1)); state_d = ssfa_pkg::S_SHIFT_WR;
          end else begin
            cnt_d = cnt_q - CW'(1);
            state_d = merge_p_q ? ssfa_pkg::S_FMERGE : ssfa_pkg::S_TOP_RD;
          end
        end
      end
      ssfa_pkg::S_SHIFT_WR: begin
        we = 1'b1; waddr = IW'(j_q); wdata = rdata_q;
        j_d = split_q ? j_q - CW'(1) : j_q + CW'(1);
        state_d = ssfa_pkg::S_SHIFT_RD;
      end
      ssfa_pkg::S_APPEND: begin
        // write the free remainder of a split
        we = 1'b1; waddr = IW'(k_q + CW'(1));
        wdata = {cs_q + sz_q, ce_q, 1'b0};
        cnt_d = cnt_q + CW'(1); state_d = ssfa_pkg::S_TOP_RD;
      end
      // Free: scan for start == addr.
      ssfa_pkg::S_FREAD: begin
        if (k_q >= cnt_q) begin
          st_d = ssfa_pkg::ST_NOT_FOUND; state_d = ssfa_pkg::S_TOP_RD;
        end else begin
          state_d = ssfa_pkg::S_FCHECK;
        end
      end
      ssfa_pkg::S_FCHECK: begin
        if (r_start == addr_q) begin
          cs_d = r_start; ce_d = r_end;
          we = 1'b1; wdata = {r_start, r_end, 1'b0};
          if (k_q + CW'(1) == cnt_q) begin
            cnt_d = (k_q != '0 && pfree_q) ? cnt_q - CW'(2) : cnt_q - CW'(1);
            state_d = ssfa_pkg::S_TOP_RD;
          end else begin
            raddr = IW'(k_q + CW'(1)); state_d = ssfa_pkg::S_FNEIGH;
          end
        end else begin
          pfree_d = !r_used;
          k_d = k_q + CW'(1); raddr = IW'(k_q + CW'(1));
          state_d = ssfa_pkg::S_FREAD;
        end
      end
      // Keep the next entry on the read port so its data is valid in the check.
      ssfa_pkg::S_FNEIGH: begin
        raddr = IW'(k_q + CW'(1)); state_d = ssfa_pkg::S_RMV_RD;
      end
      ssfa_pkg::S_RMV_RD: begin
        merge_p_d = 1'b1;
        if (!r_used) begin
          ce_d = r_end;
          we = 1'b1; wdata = {cs_q, r_end, 1'b0};
          j_d = k_q + CW'(1); lim_d = cnt_q; split_d = 1'b0;
          state_d = ssfa_pkg::S_SHIFT_RD;
        end else begin
          state_d = ssfa_pkg::S_FMERGE;
        end
      end
      ssfa_pkg::S_FMERGE: begin
        merge_p_d = 1'b0;
        if (k_q != '0 && pfree_q) begin
          raddr = IW'(k_q - CW'(1)); state_d = ssfa_pkg::S_RMV_WR;
        end else begin
          state_d = ssfa_pkg::S_TOP_RD;
        end
      end
      ssfa_pkg::S_RMV_WR: begin
        // rdata holds entry k-1; extend it and remove entry k
        we = 1'b1; waddr = IW'(k_q - CW'(1));
        wdata = {r_start, ce_q, 1'b0};
        j_d = k_q; lim_d = cnt_q; split_d = 1'b0;
        state_d = ssfa_pkg::S_SHIFT_RD;
      end
      ssfa_pkg::S_TOP_RD: begin
        raddr = IW'(cnt_q - CW'(1)); state_d = ssfa_pkg::S_TOP;
      end
      ssfa_pkg::S_TOP: begin
        top_d = (cnt_q == '0) ? '0 : r_end;
        if (merge_p_q) begin
          merge_p_d = 1'b0;
          // append path: check overflow on the freshly read top
          if (({1'b0, ((cnt_q == '0) ? {OFFSET_BITS{1'b0}} : r_end)} + {1'b0, sz_q})
              > OffMax) begin
            st_d = ssfa_pkg::ST_OVERFLOW; state_d = ssfa_pkg::S_DONE;
          end else begin
            we = 1'b1; waddr = IW'(cnt_q);
            wdata = {((cnt_q == '0) ? {OFFSET_BITS{1'b0}} : r_end),
                     ((cnt_q == '0) ? {OFFSET_BITS{1'b0}} : r_end) + sz_q, 1'b1};
            off_d = (cnt_q == '0) ? '0 : r_end;
            top_d = ((cnt_q == '0) ? {OFFSET_BITS{1'b0}} : r_end) + sz_q;
            cnt_d = cnt_q + CW'(1);
            state_d = ssfa_pkg::S_DONE;
          end
        end else begin
          state_d = ssfa_pkg::S_DONE;
        end
      end
      ssfa_pkg::S_DONE: state_d = ssfa_pkg::S_IDLE;
      default: state_d = ssfa_pkg::S_IDLE;
    endcase
  end

  assign busy_o      = (state_q != ssfa_pkg::S_IDLE);
  assign rsp_valid_o = (state_q == ssfa_pkg::S_DONE);
  assign rsp_o.slot_offset = off_q;
  assign rsp_o.status      = st_q;
  assign rsp_o.stack_top   = top_q;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

  // The slot table size and offset width follow the block's defaults.
  localparam int NumSlots = ssfa_pkg::MaxSlots;
  localparam logic [15:0] OffMax = 16'hFFFF;
  // A transaction and the longest sender gap both stay well below this idle limit.
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 4 * NumSlots + 20;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  ssfa_pkg::req_t req_i;
  logic busy_o;
  logic rsp_valid_o;
  ssfa_pkg::rsp_t rsp_o;

  stack_slot_first_fit_allocator_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow copy of the slot table that tracks what the block should hold.
  logic [15:0] tbl_start[NumSlots];
  logic [15:0] tbl_end[NumSlots];
  logic        tbl_used[NumSlots];
  int          tbl_count;

  ssfa_pkg::req_t pending_cmds[$];
  ssfa_pkg::rsp_t expected_rsps[$];
  int   gap_left;
  int   idle_cycles;
  bit   failed;
  bit   stim_done;
  bit   took_cmd;

  function automatic void queue_cmd(ssfa_pkg::req_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic logic [15:0] shadow_top();
    return (tbl_count == 0) ? 16'd0 : tbl_end[tbl_count-1];
  endfunction

  // Drops the entry at position k and closes the hole.
  function automatic void shadow_remove(int k);
    for (int j = k; j + 1 < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j+1];
      tbl_end[j]   = tbl_end[j+1];
      tbl_used[j]  = tbl_used[j+1];
    end
    tbl_count--;
  endfunction

  // First-fit allocation: exact fit, split, or append at the top.
  function automatic ssfa_pkg::status_e shadow_alloc(logic [15:0] sz,
                                                     output logic [15:0] off);
    logic [15:0] have;
    logic [16:0] sum;
    off = '0;
    for (int k = 0; k < tbl_count; k++) begin
      if (!tbl_used[k]) begin
        have = tbl_end[k] - tbl_start[k];
        if (have > sz) begin
          // A split needs a fresh entry; a full table stops the scan here.
          if (tbl_count >= NumSlots) return ssfa_pkg::ST_FULL;
          for (int j = tbl_count; j > k + 1; j--) begin
            tbl_start[j] = tbl_start[j-1];
            tbl_end[j]   = tbl_end[j-1];
            tbl_used[j]  = tbl_used[j-1];
          end
          tbl_count++;
          tbl_start[k+1] = tbl_start[k] + sz;
          tbl_end[k+1]   = tbl_end[k];
          tbl_used[k+1]  = 1'b0;
          tbl_end[k]     = tbl_start[k] + sz;
          tbl_used[k]    = 1'b1;
          off = tbl_start[k];
          return ssfa_pkg::ST_OK;
        end
        if (have == sz) begin
          tbl_used[k] = 1'b1;
          off = tbl_start[k];
          return ssfa_pkg::ST_OK;
        end
      end
    end
    if (tbl_count >= NumSlots) return ssfa_pkg::ST_FULL;
    sum = {1'b0, shadow_top()} + {1'b0, sz};
    if (sum > {1'b0, OffMax}) return ssfa_pkg::ST_OVERFLOW;
    tbl_start[tbl_count] = shadow_top();
    tbl_end[tbl_count]   = sum[15:0];
    tbl_used[tbl_count]  = 1'b1;
    off = tbl_start[tbl_count];
    tbl_count++;
    return ssfa_pkg::ST_OK;
  endfunction

  // Free by start offset, then trim the top or merge with free neighbors.
  function automatic ssfa_pkg::status_e shadow_free(logic [15:0] addr);
    for (int k = 0; k < tbl_count; k++) begin
      if (tbl_start[k] == addr) begin
        tbl_used[k] = 1'b0;
        if (k + 1 == tbl_count) begin
          if (k > 0 && !tbl_used[k-1]) tbl_count -= 2;
          else tbl_count--;
          return ssfa_pkg::ST_OK;
        end
        if (!tbl_used[k+1]) begin
          tbl_end[k] = tbl_end[k+1];
          shadow_remove(k + 1);
        end
        if (k > 0 && !tbl_used[k-1]) begin
          tbl_end[k-1] = tbl_end[k];
          shadow_remove(k);
        end
        return ssfa_pkg::ST_OK;
      end
    end
    return ssfa_pkg::ST_NOT_FOUND;
  endfunction

  function automatic ssfa_pkg::rsp_t predict_rsp(ssfa_pkg::req_t cmd);
    ssfa_pkg::rsp_t r;
    logic [15:0] off;
    off = '0;
    r.status = ssfa_pkg::ST_OK;
    case (ssfa_pkg::opcode_e'(cmd.opcode))
      ssfa_pkg::OP_ALLOC: r.status = shadow_alloc(cmd.request_size, off);
      ssfa_pkg::OP_FREE:  r.status = shadow_free(cmd.free_address);
      ssfa_pkg::OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.slot_offset = off;
    r.stack_top   = shadow_top();
    return r;
  endfunction

  // Most gaps are short; now and then a long one, and often none at all.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic ssfa_pkg::req_t make_cmd(ssfa_pkg::opcode_e op, logic [15:0] sz,
                                              logic [15:0] addr);
    ssfa_pkg::req_t c;
    c.opcode       = op;
    c.request_size = sz;
    c.free_address = addr;
    return c;
  endfunction

  // Driver: one transaction per accepted start, inputs change on falling edges.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      req_i    <= '0;
      gap_left <= 0;
    end else if (took_cmd) begin
      // Accepted at the edge just passed; the next item waits out a gap.
      void'(pending_cmds.pop_front());
      gap_left <= pick_gap();
      start_i  <= 1'b0;
    end else if (!start_i) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() > 0) begin
        start_i <= 1'b1;
        req_i   <= pending_cmds[0];
      end
    end
  end

  // Monitor: predict on acceptance, check on the result strobe.
  always @(posedge clk_i) begin
    ssfa_pkg::rsp_t exp_rsp;
    took_cmd <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if ((start_i && !busy_o) || rsp_valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start_i && !busy_o) begin
        expected_rsps = {expected_rsps, predict_rsp(req_i)};
      end
      if (rsp_valid_o) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no transaction outstanding: %h", rsp_o);
          failed = 1'b1;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_o.slot_offset !== exp_rsp.slot_offset) begin
            $error("slot_offset expected %h actual %h", exp_rsp.slot_offset,
                   rsp_o.slot_offset);
            failed = 1'b1;
          end
          if (rsp_o.status !== exp_rsp.status) begin
            $error("status expected %h actual %h", exp_rsp.status, rsp_o.status);
            failed = 1'b1;
          end
          if (rsp_o.stack_top !== exp_rsp.stack_top) begin
            $error("stack_top expected %h actual %h", exp_rsp.stack_top, rsp_o.stack_top);
            failed = 1'b1;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Picks the start of a live slot most of the time, so frees usually hit.
  function automatic logic [15:0] pick_free_addr();
    if (tbl_count > 0 && $urandom_range(0, 9) < 8)
      return tbl_start[$urandom_range(0, tbl_count - 1)];
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 16'd0;
    if (roll < 80) return 16'($urandom_range(1, 64));
    if (roll < 95) return 16'($urandom_range(65, 4096));
    return 16'($urandom());
  endfunction

  initial begin
    ssfa_pkg::req_t c;
    int roll;
    failed      = 1'b0;
    stim_done   = 1'b0;
    idle_cycles = 0;
    tbl_count   = 0;
    rst_ni      = 1'b0;

    // Directed part: empty-table corners, exact fit, split, a merge, overflow.
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd0));        // unknown address
    queue_cmd(make_cmd(ssfa_pkg::OP_NONE, 16'hFFFF, 16'hFFFF));  // unused opcode
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd0, 16'd0));       // zero-size append
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd0, 16'd0));       // second zero-size
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd0));        // equal starts
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd0, 16'd0));       // zero-size exact fit
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd100, 16'd0));
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd50, 16'd0));
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd30, 16'd0));
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd0));        // frees first zero slot
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd0));        // frees the same slot again
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd100));      // no free neighbour to merge
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd40, 16'd0));      // split
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd40));       // not found, no slot at 40
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd150));      // last slot trims top
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'hFFFF, 16'd0));    // offset overflow
    queue_cmd(make_cmd(ssfa_pkg::OP_CLEAR, 16'd0, 16'd0));
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'hFFFF, 16'd0));    // fills the range
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd1, 16'hFFFF));    // overflow by one
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'hFFFF));     // not found
    queue_cmd(make_cmd(ssfa_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF));
    // Fill the table with one-byte slots, then hit it while full.
    for (int i = 0; i < NumSlots; i++)
      queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd1, 16'd0));
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd1, 16'd0));       // append, table full
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd0));        // first slot free
    queue_cmd(make_cmd(ssfa_pkg::OP_FREE, 16'd0, 16'd1));        // merged size two
    queue_cmd(make_cmd(ssfa_pkg::OP_ALLOC, 16'd1, 16'd0));       // split refills the table
    queue_cmd(make_cmd(ssfa_pkg::OP_CLEAR, 16'd0, 16'd0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Random part. Before each free the queue drains, so the shadow table is
    // current and frees mostly name real slots.
    for (int i = 0; i < 310; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        c = make_cmd(ssfa_pkg::OP_ALLOC, pick_size(), 16'($urandom()));
      end else if (roll < 92) begin
        wait (pending_cmds.size() == 0 && expected_rsps.size() == 0 && !busy_o);
        c = make_cmd(ssfa_pkg::OP_FREE, 16'($urandom()), pick_free_addr());
      end else if (roll < 96) begin
        c = make_cmd(ssfa_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom()));
      end else begin
        c = make_cmd(ssfa_pkg::OP_NONE, 16'($urandom()), 16'($urandom()));
      end
      queue_cmd(c);
    end

    wait (pending_cmds.size() == 0);
    wait (expected_rsps.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed && expected_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ssfa_pkg.sv
rtl/core/stack_slot_first_fit_allocator_unit.sv
tb/sv/testbench.sv
